// ===== hw/rtl/tlg_pkg.sv =====
// ----------------------------------------------------------------------------
// Life generation unit package
// Field widths, item modes, rule counts and the controller command bundle.
// ----------------------------------------------------------------------------
package tlg_pkg;

    localparam int MODE_W = 2;
    localparam int POS_W  = 6;
    localparam int SIZE_W = 7;

    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_STEP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd2;

    localparam logic [SIZE_W-1:0] GRID_SIDE_RESET = 7'd64;

    // B3/S23: birth on three neighbors, survival on two or three.
    localparam logic [3:0] BIRTH_COUNT   = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    typedef struct packed {
        logic capture;        // take the input beat into the item registers
        logic cell_rd;        // read the row of the addressed cell
        logic cell_update;    // modify or sample the row read last cycle
        logic gen_rd;         // generation: read the next board row
        logic gen_shift;      // generation: advance the three-row window
        logic gen_first_src;  // generation: feed the saved first row into the window
        logic gen_cap_first;  // generation: save the original first row
        logic gen_wr;         // generation: write back one new row
        logic load_result;    // move the finished result into the output register
    } t_dp_cmd;

endpackage

// ===== hw/rtl/tlg_in_if.sv =====
// ----------------------------------------------------------------------------
// Item input channel
// Valid/ready channel that carries one command item per beat.
// ----------------------------------------------------------------------------
interface tlg_in_if;
    import tlg_pkg::*;

    logic                valid;
    logic                ready;
    logic [MODE_W-1:0]   mode;
    logic [POS_W-1:0]    row;
    logic [POS_W-1:0]    col;
    logic                cell_value;

    modport source (output valid, output mode, output row, output col, output cell_value,
                    input ready);
    modport sink   (input valid, input mode, input row, input col, input cell_value,
                    output ready);
endinterface

// ===== hw/rtl/tlg_out_if.sv =====
// ----------------------------------------------------------------------------
// Result output channel
// Valid/ready channel that carries one result per beat.
// ----------------------------------------------------------------------------
interface tlg_out_if;
    import tlg_pkg::*;

    logic                valid;
    logic                ready;
    logic                cell_state;
    logic [MODE_W-1:0]   done_kind;

    modport source (output valid, output cell_state, output done_kind, input ready);
    modport sink   (input valid, input cell_state, input done_kind, output ready);
endinterface

// ===== hw/rtl/tlg_cfg_if.sv =====
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel that writes the side length register.
// ----------------------------------------------------------------------------
interface tlg_cfg_if;
    import tlg_pkg::*;

    logic                valid;
    logic                ready;
    logic [SIZE_W-1:0]   grid_side;

    modport source (output valid, output grid_side, input ready);
    modport sink   (input valid, input grid_side, output ready);
endinterface

// ===== hw/rtl/tlg_datapath.sv =====
// ----------------------------------------------------------------------------
// Life generation datapath
// Cell store with row valid bits, three-row window, per-column neighbor
// lanes, item registers and the output register payload.
// ----------------------------------------------------------------------------
module tlg_datapath #(
    parameter int MAX_SIDE = 64,
    localparam int RW = $clog2(MAX_SIDE),
    localparam int SW = $clog2(MAX_SIDE + 1),
    localparam int CW = $clog2(MAX_SIDE + 4)
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  tlg_pkg::t_dp_cmd        i_cmd,
    input  logic [CW-1:0]           i_cnt,
    input  logic [tlg_pkg::MODE_W-1:0] i_mode,
    input  logic [tlg_pkg::POS_W-1:0]  i_row,
    input  logic [tlg_pkg::POS_W-1:0]  i_col,
    input  logic                    i_cell_value,
    input  logic                    i_cfg_wr,
    input  logic [tlg_pkg::SIZE_W-1:0] i_cfg_data,
    output logic [tlg_pkg::MODE_W-1:0] o_mode,
    output logic [SW-1:0]           o_side,
    output logic                    o_cell_state,
    output logic [tlg_pkg::MODE_W-1:0] o_done_kind
);
    import tlg_pkg::*;

    logic [SIZE_W-1:0]   r_grid_side;
    logic [MODE_W-1:0]   r_mode;
    logic [POS_W-1:0]    r_row;
    logic [POS_W-1:0]    r_col;
    logic                r_val;
    logic                r_res;
    logic                r_out_cell;
    logic [MODE_W-1:0]   r_out_kind;

    logic [MAX_SIDE-1:0] mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] r_row_valid;
    logic [MAX_SIDE-1:0] r_rd_data;
    logic                r_rd_ok;

    logic [MAX_SIDE-1:0] r_up;
    logic [MAX_SIDE-1:0] r_cur;
    logic [MAX_SIDE-1:0] r_down;
    logic [MAX_SIDE-1:0] r_first;

    logic [SW-1:0]       side;
    logic [RW-1:0]       last_idx;
    logic                on_board;
    logic [MAX_SIDE-1:0] rd_eff;
    logic [MAX_SIDE-1:0] upd_row;
    logic [MAX_SIDE-1:0] fresh;
    logic                cell_bit;
    logic                up_last;
    logic                cur_last;
    logic                down_last;
    logic                rd_en;
    logic [RW-1:0]       rd_addr;
    logic                wr_en;
    logic [RW-1:0]       wr_addr;
    logic [MAX_SIDE-1:0] wr_data;

    // Register value zero acts as side one, values above the store as the full store.
    always_comb begin
        if (r_grid_side == '0) begin
            side = SW'(1);
        end else if (32'(r_grid_side) > MAX_SIDE) begin
            side = SW'(MAX_SIDE);
        end else begin
            side = SW'(r_grid_side);
        end
    end

    assign last_idx = RW'(side - SW'(1));
    assign on_board = (32'(r_row) < 32'(side)) && (32'(r_col) < 32'(side));
    assign rd_eff   = r_rd_ok ? r_rd_data : '0;
    assign cell_bit = rd_eff[RW'(r_col)];

    always_comb begin
        upd_row = rd_eff;
        upd_row[RW'(r_col)] = r_val;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_side <= GRID_SIDE_RESET;
        end else if (i_cfg_wr) begin
            r_grid_side <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_mode;
            r_row  <= i_row;
            r_col  <= i_col;
            r_val  <= i_cell_value;
            r_res  <= 1'b0;
        end else if (i_cmd.cell_update) begin
            r_res  <= (r_mode == MODE_READ && on_board) ? cell_bit : 1'b0;
        end
        if (i_cmd.load_result) begin
            r_out_cell <= r_res;
            r_out_kind <= r_mode;
        end
    end

    // Memory port control. The generation reads row side-1 first, then rows
    // from zero upward, and writes row n back at walk position n+4, once the
    // window holds rows n-1, n and n+1.
    assign rd_en   = i_cmd.cell_rd | i_cmd.gen_rd;
    assign rd_addr = i_cmd.cell_rd ? RW'(r_row)
                   : (i_cnt == '0) ? last_idx
                   : RW'(i_cnt - CW'(1));
    assign wr_en   = i_cmd.gen_wr | (i_cmd.cell_update && r_mode == MODE_WRITE && on_board);
    assign wr_addr = i_cmd.gen_wr ? RW'(i_cnt - CW'(4)) : RW'(r_row);
    assign wr_data = i_cmd.gen_wr ? fresh : upd_row;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    // A row never written since reset reads as all dead.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_valid <= '0;
            r_rd_ok     <= 1'b0;
        end else begin
            if (wr_en) begin
                r_row_valid[wr_addr] <= 1'b1;
            end
            if (rd_en) begin
                r_rd_ok <= r_row_valid[rd_addr];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.gen_shift) begin
            r_up   <= r_cur;
            r_cur  <= r_down;
            r_down <= i_cmd.gen_first_src ? r_first : rd_eff;
        end
        if (i_cmd.gen_cap_first) begin
            r_first <= rd_eff;
        end
    end

    assign up_last   = r_up[last_idx];
    assign cur_last  = r_cur[last_idx];
    assign down_last = r_down[last_idx];

    for (genvar j = 0; j < MAX_SIDE; j++) begin : g_lane
        logic       ul, ur, cl, cr, dl, dr;
        logic [3:0] nbr;

        if (j == 0) begin : g_left_wrap
            assign ul = up_last;
            assign cl = cur_last;
            assign dl = down_last;
        end else begin : g_left
            assign ul = r_up[j-1];
            assign cl = r_cur[j-1];
            assign dl = r_down[j-1];
        end

        if (j == MAX_SIDE - 1) begin : g_right_wrap
            assign ur = r_up[0];
            assign cr = r_cur[0];
            assign dr = r_down[0];
        end else begin : g_right
            assign ur = (side == SW'(j + 1)) ? r_up[0]   : r_up[j+1];
            assign cr = (side == SW'(j + 1)) ? r_cur[0]  : r_cur[j+1];
            assign dr = (side == SW'(j + 1)) ? r_down[0] : r_down[j+1];
        end

        assign nbr = 4'(ul) + 4'(r_up[j]) + 4'(ur) + 4'(cl) + 4'(cr)
                   + 4'(dl) + 4'(r_down[j]) + 4'(dr);

        // Columns outside the active board keep their stored value.
        assign fresh[j] = (side > SW'(j))
                        ? ((nbr == BIRTH_COUNT) || (r_cur[j] && nbr == SURVIVE_COUNT))
                        : r_cur[j];
    end

    assign o_mode       = r_mode;
    assign o_side       = side;
    assign o_cell_state = r_out_cell;
    assign o_done_kind  = r_out_kind;

endmodule

// ===== hw/rtl/tlg_ctrl.sv =====
// ----------------------------------------------------------------------------
// Life generation controller
// Item sequencer: decode, cell access, row walk of a generation and the
// hand-off to the output register.
// ----------------------------------------------------------------------------
module tlg_ctrl #(
    parameter int MAX_SIDE = 64,
    localparam int SW = $clog2(MAX_SIDE + 1),
    localparam int CW = $clog2(MAX_SIDE + 4)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    input  logic [tlg_pkg::MODE_W-1:0] i_mode,
    input  logic [SW-1:0]              i_side,
    output tlg_pkg::t_dp_cmd           o_cmd,
    output logic [CW-1:0]              o_cnt
);
    import tlg_pkg::*;

    // Walk positions: first row is saved as it enters the window, and row
    // writes start once the window holds rows side-1, 0 and 1.
    localparam logic [CW-1:0] CAP_FIRST_AT = CW'(2);
    localparam logic [CW-1:0] WRITE_FROM   = CW'(4);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_CELL   = 5'b00100,
        S_GEN    = 5'b01000,
        S_DONE   = 5'b10000
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_out_valid, n_out_valid;
    logic [CW-1:0] side_ext;

    assign side_ext = CW'(i_side);

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_DECODE;
                end
            end
            S_DECODE: begin
                n_cnt = '0;
                if (i_mode == MODE_WRITE || i_mode == MODE_READ) begin
                    o_cmd.cell_rd = 1'b1;
                    n_state       = S_CELL;
                end else if (i_mode == MODE_STEP) begin
                    n_state = S_GEN;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_CELL: begin
                o_cmd.cell_update = 1'b1;
                n_state           = S_DONE;
            end
            S_GEN: begin
                o_cmd.gen_rd        = (r_cnt <= side_ext);
                o_cmd.gen_shift     = (r_cnt != '0);
                o_cmd.gen_first_src = (r_cnt == side_ext + CW'(2));
                o_cmd.gen_cap_first = (r_cnt == CAP_FIRST_AT);
                o_cmd.gen_wr        = (r_cnt >= WRITE_FROM);
                if (r_cnt == side_ext + CW'(3)) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_result = 1'b1;
                    n_state           = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.load_result) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_cnt       = r_cnt;

endmodule

// ===== hw/rtl/toroidal_life_generation_unit.sv =====
// ----------------------------------------------------------------------------
// Toroidal life generation unit
// Square cell board with cell write, cell read and B3/S23 generation step.
// ----------------------------------------------------------------------------
// The board lives in a MAX_SIDE by MAX_SIDE cell store, one row per word, and
// reads as all dead after reset through per-row valid bits, so no clearing pass
// is needed. Items are handled one at a time. The result is loaded into the
// output register after the decode and cell access states for a cell write
// or read, straight after decode for an undefined mode, and after the row walk
// for a generation step, which moves one board row per cycle
// through the single read port of the cell store. A new item is accepted on
// the cycle after its predecessor's result is loaded into the output register,
// even if that result has not yet been taken. Side register writes are accepted
// on any cycle and must only be issued while the unit is idle.
module toroidal_life_generation_unit #(
    parameter int MAX_SIDE = 64
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tlg_in_if.sink    i_in,
    tlg_out_if.source o_out,
    tlg_cfg_if.sink   i_cfg
);
    import tlg_pkg::*;

    localparam int SW = $clog2(MAX_SIDE + 1);
    localparam int CW = $clog2(MAX_SIDE + 4);

    t_dp_cmd           cmd;
    logic [CW-1:0]     cnt;
    logic [MODE_W-1:0] mode;
    logic [SW-1:0]     side;

    assign i_cfg.ready = 1'b1;

    tlg_ctrl #(
        .MAX_SIDE (MAX_SIDE)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_mode      (mode),
        .i_side      (side),
        .o_cmd       (cmd),
        .o_cnt       (cnt)
    );

    tlg_datapath #(
        .MAX_SIDE (MAX_SIDE)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cnt        (cnt),
        .i_mode       (i_in.mode),
        .i_row        (i_in.row),
        .i_col        (i_in.col),
        .i_cell_value (i_in.cell_value),
        .i_cfg_wr     (i_cfg.valid),
        .i_cfg_data   (i_cfg.grid_side),
        .o_mode       (mode),
        .o_side       (side),
        .o_cell_state (o_out.cell_state),
        .o_done_kind  (o_out.done_kind)
    );

`ifndef NO_ASSERTIONS
    // A finished result must never overwrite one that is still waiting.
    a_no_result_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_result |-> (!o_out.valid || o_out.ready))
        else $error("result register loaded while holding an untaken beat");

    // The unit is busy on the cycle after it takes an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("input beat accepted while previous item still in work");

    // The row read of a cell access is always consumed on the next cycle.
    a_cell_read_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.cell_rd |=> cmd.cell_update)
        else $error("cell row read not followed by its update");
`endif

endmodule
